FILE: hdl/gpr_pkg.sv
`timescale 1ns / 1ps

package gpr_pkg;

  // Coordinate and entry layout
  localparam int POS_W   = 17;
  localparam int STAMP_W = 32;
  localparam int ENTRY_W = 2 * POS_W + STAMP_W;

  // Shared divider widths
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 48;

  typedef enum logic [2:0] {
    CMD_BEGIN   = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_END     = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_ADVANCE = 3'd4,
    CMD_PLAY    = 3'd5,
    CMD_STOP    = 3'd6,
    CMD_SETCUR  = 3'd7
  } cmd_t;

  localparam logic CFG_BEAT_SYNC  = 1'b0;
  localparam logic CFG_LOOP_BEATS = 1'b1;

endpackage

FILE: hdl/gpr_point_mem.sv
`timescale 1ns / 1ps

module gpr_point_mem #(
  parameter int DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [gpr_pkg::ENTRY_W-1:0]   wdata,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [gpr_pkg::ENTRY_W-1:0]   rdata
);

  logic [gpr_pkg::ENTRY_W-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/gpr_div.sv
`timescale 1ns / 1ps

module gpr_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [gpr_pkg::DIV_NUM_W-1:0]   dividend,
  input  logic [gpr_pkg::DIV_DEN_W-1:0]   divisor,
  output logic                            done,
  output logic [gpr_pkg::DIV_NUM_W-1:0]   quotient,
  output logic [gpr_pkg::DIV_DEN_W-1:0]   remainder
);

  localparam int NW = gpr_pkg::DIV_NUM_W;
  localparam int DW = gpr_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW-1:0]    den;
  logic [DW:0]      trial;

  assign trial = {remainder, quotient[NW-1]};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        den       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          remainder <= DW'(trial - {1'b0, den});
          quotient  <= {quotient[NW-2:0], 1'b1};
        end else begin
          remainder <= trial[DW-1:0];
          quotient  <= {quotient[NW-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/gesture_path_recorder_player_core.sv
`timescale 1ns / 1ps
// Advance runs up to two divider passes for the phase, a scan of up to one memory read per
// stored point, and up to one divider pass for the blend weight. One command is in flight
// at a time. Reset (synchronous) returns control state and configuration to defaults;
// datapath registers and the point memory are not cleared.
module gesture_path_recorder_player_core #(
  parameter int MAX_POINTS = 256
) (
  input  logic         clk,
  input  logic         rst,
  // s_tdata: pos_x[17:0], pos_y[35:18], point_time[67:36], elapsed[87:68],
  //          beat_position[127:88]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,
  // s_tuser: command[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata: cursor_x[16:0], cursor_y[33:17], status[34], point_count[43:35],
  //          recording[44], playing[45], zero[47:46]
  output logic [47:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [19:0]  cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = gpr_pkg::ENTRY_W;
  localparam int NW = gpr_pkg::DIV_NUM_W;
  localparam int DW = gpr_pkg::DIV_DEN_W;
  localparam logic [16:0] UNIT_ONE = 17'd65536;
  localparam logic [38:0] NEAR_DIST2 = 39'd4294;
  localparam logic signed [32:0] NEAR_TIME = 33'sd102;
  localparam logic [31:0] MIN_DURATION = 32'd51;
  localparam logic [NW-1:0] NEG_T_LIMIT = 64'd4295032832;

  typedef enum logic [3:0] {
    S_IDLE, S_LAST_RD, S_LAST_CHK, S_SQX, S_SQY, S_NEAR, S_STORE, S_DIV_WT,
    S_MUL_T, S_SCAN, S_FRAC, S_MULX, S_MULY, S_FINY, S_RESP
  } state_t;

  typedef enum logic [2:0] {OP_BMOD, OP_BPH, OP_EMOD, OP_EPH, OP_FRAC} div_op_t;

  state_t          state;
  div_op_t         div_op;
  gpr_pkg::cmd_t   in_cmd;
  logic [17:0]     in_x, in_y;
  logic [31:0]     in_t;
  logic            beat_neg;
  logic            beat_sync;
  logic [19:0]     loop_beats;
  logic [CW-1:0]   count;
  logic [31:0]     duration, phase;
  logic            rec, play, status;
  logic [16:0]     cur_x, cur_y;
  logic signed [18:0] dx, dy;
  logic signed [32:0] dt;
  logic [37:0]     sq_a, sq_b;
  logic            near;
  logic [63:0]     target;
  logic [EW-1:0]   prev, cur;
  logic [CW-1:0]   iss;
  logic            a_v, d_v;
  logic [AW-1:0]   d_idx;
  logic            frac_neg;
  logic signed [33:0] tq;
  logic signed [51:0] prod;

  // Memory port
  logic            mem_we;
  logic [AW-1:0]   rd_addr;
  logic [EW-1:0]   rdata;

  // Divider port
  logic            div_start, div_done;
  logic [NW-1:0]   div_num, div_q;
  logic [DW-1:0]   div_den, div_r;

  // Input decode
  logic [39:0]     in_beat, beat_abs;
  logic [AW-1:0]   last_idx;
  logic [16:0]     cl_x, cl_y;
  logic signed [37:0] dx_w, dy_w;
  logic signed [51:0] dfx_w, dfy_w, tq_w;
  logic [31:0]     s0, s1;
  logic [63:0]     base;
  logic [19:0]     bmod_r;
  logic [NW-1:0]   neg_q;

  function automatic logic [16:0] clamp_unit(input logic [17:0] v);
    if (v[17]) begin
      return 17'd0;
    end else if (v[16:0] > UNIT_ONE) begin
      return UNIT_ONE;
    end else begin
      return v[16:0];
    end
  endfunction

  function automatic logic [16:0] blend_fin(input logic [16:0] a0,
                                            input logic signed [51:0] p);
    logic signed [53:0] acc;
    logic signed [37:0] r;
    acc = $signed({21'd0, a0, 16'd0}) + 54'(p) + 54'sd32768;
    r = acc[53:16];
    if (r < 0) begin
      return 17'd0;
    end else if (r > $signed({21'd0, UNIT_ONE})) begin
      return UNIT_ONE;
    end else begin
      return r[16:0];
    end
  endfunction

  assign in_beat   = s_tdata[127:88];
  assign beat_abs  = in_beat[39] ? 40'(-in_beat) : in_beat;
  assign last_idx  = AW'(count - CW'(1));
  assign cl_x      = clamp_unit(in_x);
  assign cl_y      = clamp_unit(in_y);
  assign dx_w      = 38'(dx);
  assign dy_w      = 38'(dy);
  assign tq_w      = 52'(tq);
  assign dfx_w     = 52'($signed({1'b0, cur[16:0]}) - $signed({1'b0, prev[16:0]}));
  assign dfy_w     = 52'($signed({1'b0, cur[33:17]}) - $signed({1'b0, prev[33:17]}));
  assign s0        = prev[65:34];
  assign s1        = cur[65:34];
  assign base      = {s0, 32'd0};
  assign bmod_r    = (beat_neg && div_r[19:0] != 20'd0) ? loop_beats - div_r[19:0]
                                                        : div_r[19:0];
  assign neg_q     = (div_q >= NEG_T_LIMIT) ? NEG_T_LIMIT
                                            : div_q + NW'(div_r != '0);
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // The write lands in the cycle after the count advances, so address the newest entry
  gpr_point_mem #(
    .DEPTH (MAX_POINTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (last_idx),
    .wdata ({in_t, cl_y, cl_x}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  gpr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      beat_sync  <= 1'b1;
      loop_beats <= 20'd4096;
      count      <= '0;
      duration   <= '0;
      phase      <= '0;
      rec        <= 1'b0;
      play       <= 1'b0;
      status     <= 1'b0;
      cur_x      <= 17'd32768;
      cur_y      <= 17'd32768;
      div_start  <= 1'b0;
      mem_we     <= 1'b0;
      a_v        <= 1'b0;
      d_v        <= 1'b0;
    end else begin
      div_start <= 1'b0;
      mem_we    <= 1'b0;

      // Take configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          gpr_pkg::CFG_BEAT_SYNC:  beat_sync  <= cfg_data[0];
          gpr_pkg::CFG_LOOP_BEATS: loop_beats <= cfg_data;
          default: ;
        endcase
      end

      // Drop the result once taken
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_cmd   <= gpr_pkg::cmd_t'(s_tuser);
            in_x     <= s_tdata[17:0];
            in_y     <= s_tdata[35:18];
            in_t     <= s_tdata[67:36];
            beat_neg <= in_beat[39];
            status   <= 1'b0;
            state    <= S_RESP;
            case (gpr_pkg::cmd_t'(s_tuser))
              gpr_pkg::CMD_BEGIN: begin
                count    <= '0;
                duration <= '0;
                phase    <= '0;
                rec      <= 1'b1;
                play     <= 1'b0;
              end
              gpr_pkg::CMD_ADD: begin
                if (!rec) begin
                  status <= 1'b1;
                end else if (count == '0) begin
                  near  <= 1'b0;
                  state <= S_STORE;
                end else begin
                  rd_addr <= last_idx;
                  state   <= S_LAST_RD;
                end
              end
              gpr_pkg::CMD_END: begin
                rec <= 1'b0;
                if (count < CW'(2)) begin
                  count    <= '0;
                  duration <= '0;
                  phase    <= '0;
                  play     <= 1'b0;
                end else begin
                  rd_addr <= last_idx;
                  state   <= S_LAST_RD;
                end
              end
              gpr_pkg::CMD_CLEAR: begin
                count    <= '0;
                duration <= '0;
                phase    <= '0;
                rec      <= 1'b0;
                play     <= 1'b0;
              end
              gpr_pkg::CMD_ADVANCE: begin
                if (!play || count < CW'(2)) begin
                  status <= 1'b1;
                end else if (beat_sync) begin
                  if (loop_beats == '0) begin
                    phase <= '0;
                    state <= S_MUL_T;
                  end else begin
                    div_num   <= NW'(beat_abs);
                    div_den   <= DW'(loop_beats);
                    div_op    <= OP_BMOD;
                    div_start <= 1'b1;
                    state     <= S_DIV_WT;
                  end
                end else if (duration == '0) begin
                  state <= S_MUL_T;
                end else begin
                  div_num   <= NW'(s_tdata[87:68]);
                  div_den   <= DW'(duration);
                  div_op    <= OP_EMOD;
                  div_start <= 1'b1;
                  state     <= S_DIV_WT;
                end
              end
              gpr_pkg::CMD_PLAY: begin
                if (count < CW'(2)) begin
                  status <= 1'b1;
                end else begin
                  play <= 1'b1;
                end
              end
              gpr_pkg::CMD_STOP: begin
                play <= 1'b0;
              end
              default: begin
                cur_x <= clamp_unit(s_tdata[17:0]);
                cur_y <= clamp_unit(s_tdata[35:18]);
              end
            endcase
          end
        end

        S_LAST_RD: begin
          state <= S_LAST_CHK;
        end

        // Use the last stored point
        S_LAST_CHK: begin
          if (in_cmd == gpr_pkg::CMD_END) begin
            duration <= (rdata[65:34] < MIN_DURATION) ? MIN_DURATION : rdata[65:34];
            state    <= S_RESP;
          end else begin
            dx    <= $signed({in_x[17], in_x}) - $signed({2'b0, rdata[16:0]});
            dy    <= $signed({in_y[17], in_y}) - $signed({2'b0, rdata[33:17]});
            dt    <= $signed({1'b0, in_t}) - $signed({1'b0, rdata[65:34]});
            state <= S_SQX;
          end
        end

        S_SQX: begin
          sq_a  <= 38'(dx_w * dx_w);
          state <= S_SQY;
        end

        S_SQY: begin
          sq_b  <= 38'(dy_w * dy_w);
          state <= S_NEAR;
        end

        S_NEAR: begin
          near  <= ({1'b0, sq_a} + {1'b0, sq_b} <= NEAR_DIST2) && (dt <= NEAR_TIME);
          state <= S_STORE;
        end

        // Store the point unless decimated or full
        S_STORE: begin
          if (near || count >= CW'(MAX_POINTS)) begin
            status <= 1'b1;
          end else begin
            mem_we   <= 1'b1;
            count    <= count + CW'(1);
            duration <= in_t;
          end
          state <= S_RESP;
        end

        S_DIV_WT: begin
          if (div_done) begin
            case (div_op)
              OP_BMOD: begin
                div_num   <= {NW'(bmod_r) << 32};
                div_den   <= DW'(loop_beats);
                div_op    <= OP_BPH;
                div_start <= 1'b1;
              end
              OP_BPH: begin
                phase <= div_q[31:0];
                state <= S_MUL_T;
              end
              OP_EMOD: begin
                div_num   <= {div_r[31:0], 32'd0};
                div_den   <= DW'(duration);
                div_op    <= OP_EPH;
                div_start <= 1'b1;
              end
              OP_EPH: begin
                phase <= phase + div_q[31:0];
                state <= S_MUL_T;
              end
              default: begin
                tq    <= frac_neg ? -$signed(neg_q[33:0]) : $signed(div_q[33:0]);
                state <= S_MULX;
              end
            endcase
          end
        end

        // Form the target and start the scan at entry zero
        S_MUL_T: begin
          target  <= 64'(phase) * 64'(duration);
          rd_addr <= '0;
          a_v     <= 1'b1;
          d_v     <= 1'b0;
          iss     <= CW'(1);
          state   <= S_SCAN;
        end

        S_SCAN: begin
          d_v   <= a_v;
          d_idx <= rd_addr;
          a_v   <= (iss < count);
          if (iss < count) begin
            rd_addr <= iss[AW-1:0];
          end
          iss <= iss + CW'(1);
          if (d_v) begin
            if (d_idx == '0) begin
              prev <= rdata;
            end else if ({rdata[65:34], 32'd0} >= target) begin
              cur   <= rdata;
              a_v   <= 1'b0;
              d_v   <= 1'b0;
              state <= S_FRAC;
            end else if (d_idx == last_idx) begin
              cur_x <= rdata[16:0];
              cur_y <= rdata[33:17];
              a_v   <= 1'b0;
              d_v   <= 1'b0;
              state <= S_RESP;
            end else begin
              prev <= rdata;
            end
          end
        end

        // Set up the weight division, or use a zero weight when the stamps do not increase
        S_FRAC: begin
          if (s1 <= s0) begin
            tq    <= '0;
            state <= S_MULX;
          end else begin
            frac_neg  <= (target < base);
            div_num   <= (target >= base) ? target - base : base - target;
            div_den   <= {s1 - s0, 16'd0};
            div_op    <= OP_FRAC;
            div_start <= 1'b1;
            state     <= S_DIV_WT;
          end
        end

        S_MULX: begin
          prod  <= dfx_w * tq_w;
          state <= S_MULY;
        end

        S_MULY: begin
          cur_x <= blend_fin(prev[16:0], prod);
          prod  <= dfy_w * tq_w;
          state <= S_FINY;
        end

        S_FINY: begin
          cur_y <= blend_fin(prev[33:17], prod);
          state <= S_RESP;
        end

        // Hand over the result when the output register is free
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {2'b00, play, rec, 9'(count), status, cur_y, cur_x};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/gesture_path_recorder_player_core_tb.sv
`timescale 1ns / 1ps

module gesture_path_recorder_player_core_tb;

  localparam int NPTS = 256;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [47:0]  m_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [0:0]   cfg_index;
  logic [19:0]  cfg_data;

  gesture_path_recorder_player_core #(.MAX_POINTS(NPTS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic       playing;
    logic       recording;
    logic [8:0] count;
    logic       status;
    logic [16:0] cy;
    logic [16:0] cx;
  } cursor_report_t;

  // Shadow copy of the path player
  logic        sh_beat_sync;
  logic [19:0] sh_loop_beats;
  logic [16:0] sh_px [NPTS];
  logic [16:0] sh_py [NPTS];
  logic [31:0] sh_stamp [NPTS];
  int          sh_count;
  logic [31:0] sh_duration;
  logic [31:0] sh_phase;
  logic        sh_rec;
  logic        sh_play;
  logic [16:0] sh_cx;
  logic [16:0] sh_cy;

  cursor_report_t report_q[$];
  int  errors;
  int  results_seen;
  int  items_sent;
  bit  idle_en;
  bit  hold_rx;
  int  hold_cycles;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic logic [16:0] clamp_unit(longint v);
    if (v < 0) return 17'd0;
    if (v > 65536) return 17'd65536;
    return v[16:0];
  endfunction

  function automatic logic [16:0] blend_coord(longint a0, longint a1, longint tq);
    longint acc;
    longint r;
    acc = a0 * 65536 + (a1 - a0) * tq + 32768;
    r = acc >>> 16;
    return clamp_unit(r);
  endfunction

  task automatic reset_path();
    sh_count = 0;
    sh_duration = '0;
    sh_phase = '0;
    sh_play = 1'b0;
    sh_rec = 1'b0;
  endtask

  // Walk the path for the first stamp at or past phase*duration and interpolate, else hold the last point
  task automatic sample_cursor();
    logic [63:0] target;
    logic [63:0] base;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] q;
    longint span;
    longint tq;
    target = 64'(sh_phase) * 64'(sh_duration);
    for (int i = 1; i < sh_count; i++) begin
      if ({sh_stamp[i], 32'd0} >= target) begin
        span = longint'(sh_stamp[i]) - longint'(sh_stamp[i-1]);
        tq = 0;
        if (span > 0) begin
          base = {sh_stamp[i-1], 32'd0};
          s = 64'(span) << 16;
          if (target >= base) begin
            tq = longint'((target - base) / s);
          end else begin
            m = base - target;
            q = m / s;
            if (m % s != 0) q++;
            if (q > 64'd4295032832) q = 64'd4295032832;
            tq = -longint'(q);
          end
        end
        sh_cx = blend_coord(sh_px[i-1], sh_px[i], tq);
        sh_cy = blend_coord(sh_py[i-1], sh_py[i], tq);
        return;
      end
    end
    sh_cx = sh_px[sh_count-1];
    sh_cy = sh_py[sh_count-1];
  endtask

  // Apply one command to the shadow state and queue the report it yields
  task automatic predict_command(gpr_pkg::cmd_t cmd, logic signed [17:0] x,
                                 logic signed [17:0] y,
                                 logic [31:0] t, logic [19:0] el,
                                 logic signed [39:0] beat);
    cursor_report_t rep;
    logic st;
    longint dx, dy, dt, r, len;
    logic [63:0] inc;
    st = 1'b0;
    case (cmd)
      gpr_pkg::CMD_BEGIN: begin
        sh_count = 0; sh_duration = '0; sh_phase = '0; sh_rec = 1'b1; sh_play = 1'b0;
      end
      gpr_pkg::CMD_ADD: begin
        if (!sh_rec) begin
          st = 1'b1;
        end else begin
          if (sh_count > 0) begin
            dx = longint'(x) - longint'(sh_px[sh_count-1]);
            dy = longint'(y) - longint'(sh_py[sh_count-1]);
            dt = longint'(t) - longint'(sh_stamp[sh_count-1]);
            if (dx*dx + dy*dy <= 4294 && dt <= 102) st = 1'b1;
          end
          if (!st && sh_count >= NPTS) st = 1'b1;
          if (!st) begin
            sh_px[sh_count] = clamp_unit(x);
            sh_py[sh_count] = clamp_unit(y);
            sh_stamp[sh_count] = t;
            sh_count++;
            sh_duration = t;
          end
        end
      end
      gpr_pkg::CMD_END: begin
        sh_rec = 1'b0;
        if (sh_count < 2) reset_path();
        else sh_duration = (sh_stamp[sh_count-1] < 51) ? 32'd51 : sh_stamp[sh_count-1];
      end
      gpr_pkg::CMD_CLEAR: reset_path();
      gpr_pkg::CMD_ADVANCE: begin
        if (!sh_play || sh_count < 2) begin
          st = 1'b1;
        end else begin
          if (sh_beat_sync) begin
            if (sh_loop_beats == 0) begin
              sh_phase = '0;
            end else begin
              len = sh_loop_beats;
              r = longint'(beat) % len;
              if (r < 0) r += len;
              sh_phase = 32'((64'(r) << 32) / 64'(len));
            end
          end else if (sh_duration > 0) begin
            inc = ((64'(el) % 64'(sh_duration)) << 32) / 64'(sh_duration);
            sh_phase = sh_phase + inc[31:0];
          end
          sample_cursor();
        end
      end
      gpr_pkg::CMD_PLAY: begin
        if (sh_count < 2) st = 1'b1;
        else sh_play = 1'b1;
      end
      gpr_pkg::CMD_STOP: sh_play = 1'b0;
      default: begin
        sh_cx = clamp_unit(x);
        sh_cy = clamp_unit(y);
      end
    endcase
    rep.cx = sh_cx;
    rep.cy = sh_cy;
    rep.status = st;
    rep.count = 9'(sh_count);
    rep.recording = sh_rec;
    rep.playing = sh_play;
    report_q = {report_q, rep};
  endtask

  // Random idle cycles on the sending side
  task automatic sender_gap();
    while (idle_en && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_command(gpr_pkg::cmd_t cmd, logic signed [17:0] x,
                              logic signed [17:0] y,
                              logic [31:0] t, logic [19:0] el,
                              logic signed [39:0] beat);
    sender_gap();
    s_tdata <= {beat, el, t, y, x};
    s_tuser <= cmd;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_command(cmd, x, y, t, el, beat);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_simple(gpr_pkg::cmd_t cmd);
    send_command(cmd, 18'sd0, 18'sd0, 32'd0, 20'd0, 40'sd0);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == gpr_pkg::CFG_BEAT_SYNC) sh_beat_sync = val[0];
    else sh_loop_beats = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: random back-pressure and a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_rx) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(idle_en && $urandom_range(99) < 34);
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      if (hold_cycles == 0) hold_rx = 1'b0;
    end
  end

  // Compare each output transaction against the oldest prediction
  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[45:0];
      results_seen++;
      if (report_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = report_q.pop_front();
        if (got.cx !== exp_r.cx)
          $display("%0t: cursor_x expected %0d actual %0d", $time, exp_r.cx, got.cx);
        if (got.cy !== exp_r.cy)
          $display("%0t: cursor_y expected %0d actual %0d", $time, exp_r.cy, got.cy);
        if (got.status !== exp_r.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        if (got.count !== exp_r.count)
          $display("%0t: point_count expected %0d actual %0d", $time, exp_r.count, got.count);
        if (got.recording !== exp_r.recording)
          $display("%0t: recording expected %0d actual %0d", $time, exp_r.recording,
                   got.recording);
        if (got.playing !== exp_r.playing)
          $display("%0t: playing expected %0d actual %0d", $time, exp_r.playing, got.playing);
        if (m_tdata[47:46] !== 2'b00)
          $display("%0t: pad bits expected 0 actual %b", $time, m_tdata[47:46]);
        if (got !== exp_r || m_tdata[47:46] !== 2'b00) errors++;
      end
    end
  end

  function automatic logic signed [17:0] rand_pos();
    case ($urandom_range(5))
      0: return 18'($urandom);
      1: return 18'(-18'sd1 * $urandom_range(3000));
      2: return 18'(18'sd65536 + $urandom_range(3000));
      default: return 18'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic signed [39:0] rand_beat();
    return 40'({$urandom, $urandom});
  endfunction

  // Record a path with random positions and mostly rising stamps
  task automatic record_path(int npts, int step);
    logic [31:0] t;
    t = $urandom_range(50);
    send_simple(gpr_pkg::CMD_BEGIN);
    for (int i = 0; i < npts; i++) begin
      send_command(gpr_pkg::CMD_ADD, rand_pos(), rand_pos(), t, 20'($urandom), rand_beat());
      t = t + $urandom_range(step);
      if ($urandom_range(9) == 0) t = t - $urandom_range(40);
    end
    send_simple(gpr_pkg::CMD_END);
  endtask

  task automatic test_directed();
    send_simple(gpr_pkg::CMD_ADVANCE);
    send_simple(gpr_pkg::CMD_PLAY);
    send_command(gpr_pkg::CMD_ADD, 18'sd100, 18'sd100, 32'd5, 20'd0, 40'sd0);
    send_command(gpr_pkg::CMD_SETCUR, -18'sd131072, 18'sd131071, 32'd0, 20'd0, 40'sd0);
    send_command(gpr_pkg::CMD_SETCUR, 18'sd65536, 18'sd0, 32'd0, 20'd0, 40'sd0);
    send_simple(gpr_pkg::CMD_BEGIN);
    send_command(gpr_pkg::CMD_ADD, 18'sd1000, 18'sd1000, 32'd0, 20'd0, 40'sd0);
    // decimated: close and soon
    send_command(gpr_pkg::CMD_ADD, 18'sd1040, 18'sd1010, 32'd102, 20'd0, 40'sd0);
    // close and soon as well: also decimated
    send_command(gpr_pkg::CMD_ADD, 18'sd1040, 18'sd1010, 32'd20, 20'd0, 40'sd0);
    send_command(gpr_pkg::CMD_ADD, -18'sd131072, 18'sd131071, 32'hFFFF_FFFF, 20'd0, 40'sd0);
    send_command(gpr_pkg::CMD_ADD, 18'sd65536, 18'sd0, 32'd10, 20'd0, 40'sd0);
    send_simple(gpr_pkg::CMD_END);
    send_simple(gpr_pkg::CMD_PLAY);
    send_command(gpr_pkg::CMD_ADVANCE, 18'sd0, 18'sd0, 32'd0, 20'hFFFFF, 40'sh7F_FFFF_FFFF);
    send_command(gpr_pkg::CMD_ADVANCE, 18'sd0, 18'sd0, 32'd0, 20'd0, 40'sh80_0000_0000);
    send_command(gpr_pkg::CMD_ADVANCE, 18'sd0, 18'sd0, 32'd0, 20'd1, -40'sd1);
    send_simple(gpr_pkg::CMD_STOP);
    send_simple(gpr_pkg::CMD_ADVANCE);
    // end with one point clears
    send_simple(gpr_pkg::CMD_BEGIN);
    send_command(gpr_pkg::CMD_ADD, 18'sd5, 18'sd5, 32'd3, 20'd0, 40'sd0);
    send_simple(gpr_pkg::CMD_END);
    // short path gets the minimum duration
    send_simple(gpr_pkg::CMD_BEGIN);
    send_command(gpr_pkg::CMD_ADD, 18'sd0, 18'sd0, 32'd0, 20'd0, 40'sd0);
    send_command(gpr_pkg::CMD_ADD, 18'sd65536, 18'sd65536, 32'd10, 20'd0, 40'sd0);
    send_simple(gpr_pkg::CMD_END);
    send_simple(gpr_pkg::CMD_CLEAR);
    wait_drained();
  endtask

  task automatic test_fill_store();
    logic [31:0] t;
    t = 32'd0;
    send_simple(gpr_pkg::CMD_BEGIN);
    for (int i = 0; i < NPTS + 3; i++) begin
      send_command(gpr_pkg::CMD_ADD, 18'(i * 200), 18'(65536 - i * 200), t, 20'd0, 40'sd0);
      t = t + 7;
    end
    send_simple(gpr_pkg::CMD_END);
    send_simple(gpr_pkg::CMD_PLAY);
    for (int i = 0; i < 6; i++)
      send_command(gpr_pkg::CMD_ADVANCE, 18'sd0, 18'sd0, 32'd0, 20'($urandom), rand_beat());
    wait_drained();
  endtask

  // Mostly record/play/advance sessions, plus random noise commands
  task automatic test_random_sessions(int budget, bit free_run);
    int n;
    while (items_sent < budget) begin
      if ($urandom_range(9) < 8) begin
        n = ($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(1, 8);
        record_path(n, $urandom_range(1, 2000));
        send_simple(gpr_pkg::CMD_PLAY);
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(19) == 0) send_simple(gpr_pkg::CMD_STOP);
          else if ($urandom_range(19) == 0) send_simple(gpr_pkg::CMD_PLAY);
          send_command(gpr_pkg::CMD_ADVANCE, rand_pos(), rand_pos(), $urandom,
                       free_run ? 20'($urandom_range(3000)) : 20'($urandom), rand_beat());
        end
      end else begin
        send_command(gpr_pkg::cmd_t'($urandom_range(7)), 18'($urandom), 18'($urandom),
                     $urandom, 20'($urandom), rand_beat());
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    hold_cycles = 600;
    record_path(10, 300);
    send_simple(gpr_pkg::CMD_PLAY);
    for (int i = 0; i < 10; i++)
      send_command(gpr_pkg::CMD_ADVANCE, 18'sd0, 18'sd0, 32'd0, 20'($urandom), rand_beat());
    // sender waits for everything to come back before going on
    wait_drained();
    send_simple(gpr_pkg::CMD_ADVANCE);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = gpr_pkg::CMD_BEGIN;
    cfg_valid = 1'b0; cfg_index = gpr_pkg::CFG_BEAT_SYNC; cfg_data = '0;
    errors = 0; results_seen = 0; items_sent = 0;
    idle_en = 1'b1; hold_rx = 1'b0; hold_cycles = 0;
    sh_beat_sync = 1'b1; sh_loop_beats = 20'd4096;
    sh_cx = 17'd32768; sh_cy = 17'd32768;
    reset_path();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (3) @(negedge clk);

    test_directed();
    test_fill_store();
    write_reg(gpr_pkg::CFG_BEAT_SYNC, 20'd0);
    test_random_sessions(500, 1'b1);
    write_reg(gpr_pkg::CFG_BEAT_SYNC, 20'd1);
    write_reg(gpr_pkg::CFG_LOOP_BEATS, 20'd0);
    test_random_sessions(650, 1'b0);
    write_reg(gpr_pkg::CFG_LOOP_BEATS, 20'hFFFFF);
    idle_en = 1'b0;
    test_random_sessions(900, 1'b0);
    idle_en = 1'b1;
    write_reg(gpr_pkg::CFG_LOOP_BEATS, 20'd1);
    test_random_sessions(1050, 1'b0);
    write_reg(gpr_pkg::CFG_LOOP_BEATS, 20'($urandom_range(1, 20000)));
    test_random_sessions(1350, 1'b0);
    write_reg(gpr_pkg::CFG_BEAT_SYNC, 20'd0);
    test_backpressure();
    test_random_sessions(1650, 1'b1);

    $display("Covered %0d commands and %0d cursor reports over free-running and beat-locked",
             items_sent, results_seen);
    $display("playback, loop lengths 0/1/max, a full point store and output back-pressure.");
    if (errors == 0 && report_q.size() == 0) begin
      $display("gesture_path_recorder_player_core: match");
    end else begin
      $display("gesture_path_recorder_player_core: mismatch");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("gesture_path_recorder_player_core: mismatch");
    $finish;
  end

endmodule
